@@ rtl/sha256_pkg.sv @@
// sha-256 constants, round table and bit-mixing functions
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;

  // round constants, one per compression round
  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value
  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

@@ rtl/sha256_if.sv @@
// valid/ready channel interfaces for message bytes and digest words
`timescale 1ns / 1ps
`default_nettype none

interface sha256_byte_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, has_byte, data_byte, last_byte, input ready);
  modport sink   (input valid, has_byte, data_byte, last_byte, output ready);
endinterface

interface sha256_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

@@ rtl/sha256_byte_stream_hasher_top.sv @@
// sha-256 hasher over a byte stream, one shared round unit under a sequencer
//
//   channel   dir  payload                                   ends on
//   byte_i    in   has_byte, data_byte[7:0], last_byte        last_byte
//   digest_o  out  digest_word[31:0], word_index[2:0], last   last_word
//
// a byte item is taken while idle; the 64th byte of a block starts compression
// (64 rounds through the single round unit, then a feed-forward step).
// a last item adds 9 to 72 padding bytes, one per cycle outside compression,
// one or two block compressions, then 8 digest transfers.
// byte_i is ready only while the sequencer is idle; digest_o stalls hold
// the sequencer in the output state. reset needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_top
  import sha256_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  sha256_byte_if.sink      byte_i,
  sha256_digest_if.source  digest_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_e;

  state_e       state_q, state_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  bits_q, bits_d;
  logic         pad_q, pad_d;
  logic         first_q, first_d;
  logic         two_blk_q, two_blk_d;
  logic         fin_q, fin_d;
  logic [2:0]   idx_q, idx_d;
  word_t        chain_q [8];
  word_t        chain_d [8];
  word_t        v_q [8];
  word_t        v_d [8];
  logic [511:0] blk_q, blk_d;

  logic         in_fire, out_fire;
  logic         push;
  logic [7:0]   push_byte;
  logic [7:0]   len_byte;
  logic [7:0]   pad_byte;
  logic         len_phase;
  word_t        w0, w1, w9, w14, w_new;
  word_t        t1, t2;

  assign in_fire  = byte_i.valid && byte_i.ready;
  assign out_fire = digest_o.valid && digest_o.ready;

  // message schedule window, oldest word at the top of the block register
  assign w0    = blk_q[511:480];
  assign w1    = blk_q[479:448];
  assign w9    = blk_q[223:192];
  assign w14   = blk_q[63:32];
  assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

  // shared round unit
  assign t1 = v_q[7] + big_sig1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
            + K_TABLE[rnd_q] + w0;
  assign t2 = big_sig0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

  // padding byte: marker, zeros, then big-endian bit length
  assign len_byte  = bits_q[{~fill_q[2:0], 3'b000} +: 8];
  assign len_phase = !first_q && (fill_q >= LEN_START) && !two_blk_q;
  assign pad_byte  = first_q ? PAD_MARK : (len_phase ? len_byte : 8'h00);

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    pad_d     = pad_q;
    first_d   = first_q;
    two_blk_d = two_blk_q;
    fin_d     = fin_q;
    idx_d     = idx_q;
    chain_d   = chain_q;
    v_d       = v_q;
    blk_d     = blk_q;
    push      = 1'b0;
    push_byte = byte_i.data_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_i.has_byte) begin
            push   = 1'b1;
            bits_d = bits_q + 64'd8;
          end
          if (byte_i.last_byte) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
        first_d   = 1'b0;
        if (first_q) begin
          two_blk_d = (fill_q >= LEN_START) && (fill_q != FILL_LAST);
        end else if (fill_q == FILL_LAST) begin
          two_blk_d = 1'b0;
        end
        if (len_phase && fill_q == FILL_LAST) begin
          fin_d = 1'b1;
        end
      end
      ST_ROUND: begin
        blk_d = {blk_q[479:0], w_new};
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        if (fin_q) begin
          fin_d   = 1'b0;
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == WORD_LAST) begin
            chain_d = H_INIT;
            bits_d  = '0;
            pad_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // byte into the block; a full block starts compression
    if (push) begin
      blk_d  = {blk_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == FILL_LAST) begin
        v_d     = chain_q;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
    end
  end

  // sequencer, counters and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rnd_q     <= '0;
      fill_q    <= '0;
      bits_q    <= '0;
      pad_q     <= 1'b0;
      first_q   <= 1'b0;
      two_blk_q <= 1'b0;
      fin_q     <= 1'b0;
      idx_q     <= '0;
      chain_q   <= H_INIT;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      fill_q    <= fill_d;
      bits_q    <= bits_d;
      pad_q     <= pad_d;
      first_q   <= first_d;
      two_blk_q <= two_blk_d;
      fin_q     <= fin_d;
      idx_q     <= idx_d;
      chain_q   <= chain_d;
    end
  end

  // block buffer and working variables
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
  end

  // channel outputs
  assign byte_i.ready         = (state_q == ST_IDLE);
  assign digest_o.valid       = (state_q == ST_OUT);
  assign digest_o.digest_word = chain_q[idx_q];
  assign digest_o.word_index  = idx_q;
  assign digest_o.last_word   = (idx_q == WORD_LAST);

endmodule

`default_nettype wire

@@ rtl/sha256_checker.sv @@
// port-level checks for the sha-256 hasher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sha256_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_last_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [2:0]  out_index_i,
  input wire        out_last_i
);

  // no byte transfer while digest words are on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
  else $error("byte channel ready during digest output");

  // a last byte closes the input: ready is low after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
  else $error("input reopened after last byte");

  // digest words come in index order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !out_last_i) |=>
      (out_valid_i && out_index_i == $past(out_index_i) + 3'd1))
  else $error("digest word index out of order");

  // final word flag matches the index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == 3'd7)))
  else $error("last word flag does not match index");

  // after the final word the output goes quiet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> !out_valid_i)
  else $error("digest output continued after last word");

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_sha256_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .in_last_i   (byte_i.last_byte),
  .out_valid_i (digest_o.valid),
  .out_ready_i (digest_o.ready),
  .out_index_i (digest_o.word_index),
  .out_last_i  (digest_o.last_word)
);

`default_nettype wire
